@@ rtl/core/psat_pkg.sv @@
// shared types and constants for the per-source accept throttle
package psat_pkg;

   // address family codes
   localparam logic [1:0] FAM_NONE = 2'd0;
   localparam logic [1:0] FAM_IPV4 = 2'd1;
   localparam logic [1:0] FAM_IPV6 = 2'd2;
   localparam logic [1:0] FAM_RSVD = 2'd3;

   // configuration register indexes
   localparam logic CSR_WINDOW_LENGTH = 1'b0;
   localparam logic CSR_MAX_PER_WINDOW = 1'b1;

   // configuration reset values
   localparam logic [31:0] WINDOW_LENGTH_RST = 32'd1000;
   localparam logic [15:0] MAX_PER_WINDOW_RST = 16'd10;

   // bucket entry layout in the table memory
   localparam int ADDR_W = 64;
   localparam int TIME_W = 32;
   localparam int CNT_W = 16;
   localparam int ENTRY_W = 2 * ADDR_W + TIME_W + CNT_W;

   // result outcome codes
   typedef enum logic [2:0] {
      OUT_UNTRACKED = 3'd0,
      OUT_COUNTED   = 3'd1,
      OUT_REFUSED   = 3'd2,
      OUT_NEW       = 3'd3,
      OUT_CLEARED   = 3'd4
   } outcome_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic start_scan;
      logic scan_en;
      logic clear_tbl;
      logic set_clear_res;
      logic set_untracked_res;
      logic write_entry;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_clear;
      logic is_untracked;
      logic scan_hit;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

@@ rtl/core/psat_ctrl.sv @@
// controller state machine for the per-source accept throttle
module psat_ctrl import psat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (sts.is_clear || sts.is_untracked) state_in = ST_FINISH;
            else state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_hit || sts.scan_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.start_scan = 1'b1;
            cmd.clear_tbl = sts.is_clear;
            cmd.set_clear_res = sts.is_clear;
            cmd.set_untracked_res = !sts.is_clear && sts.is_untracked;
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
         end
         ST_UPDATE: begin
            cmd.write_entry = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_rsp = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // a word is only taken when no other request is in flight
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DECODE)
      else $error("request taken outside idle");

endmodule

@@ rtl/core/psat_dp.sv @@
// datapath for the per-source accept throttle: bucket table, scan and result
module psat_dp import psat_pkg::*; #(
   parameter int BUCKETS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        req_type,
   input  logic [1:0]  req_addr_family,
   input  logic [63:0] req_addr_upper,
   input  logic [63:0] req_addr_lower,
   input  logic [31:0] req_now_ms,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic        rsp_allowed,
   output logic [2:0]  rsp_outcome,
   output logic [3:0]  rsp_bucket_index
);

   localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);

   // configuration
   logic [TIME_W-1:0] window_ff;
   logic [CNT_W-1:0]  max_ff;

   // captured request
   logic              clr_ff;
   logic [1:0]        req_fam_ff;
   logic [ADDR_W-1:0] req_up_ff;
   logic [ADDR_W-1:0] req_lo_ff;
   logic [TIME_W-1:0] now_ff;

   // table storage
   logic [1:0]         family_ff [BUCKETS];
   logic [ENTRY_W-1:0] bucket_mem [BUCKETS];

   // scan pipeline
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               issue_done_ff;
   logic               chk_vld_ff;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [1:0]         rd_fam_ff;
   logic               issuing;

   // scan trackers
   logic              empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]  empty_idx_ff, empty_idx_in;
   logic              exp_found_ff, exp_found_in;
   logic [IDX_W-1:0]  exp_idx_ff, exp_idx_in;
   logic [IDX_W-1:0]  oldest_idx_ff, oldest_idx_in;
   logic [TIME_W-1:0] oldest_age_ff, oldest_age_in;
   logic [IDX_W-1:0]  slot;

   // bucket update and result
   logic [IDX_W-1:0]  upd_idx_ff;
   logic [TIME_W-1:0] upd_start_ff;
   logic [CNT_W-1:0]  upd_cnt_ff;
   logic              res_allowed_ff;
   outcome_type       res_outcome_ff;
   logic [IDX_W-1:0]  res_idx_ff;
   logic [IDX_W+3:0]  res_idx_wide;

   // output register
   logic              rsp_valid_ff;
   logic              rsp_allowed_ff;
   outcome_type       rsp_outcome_ff;
   logic [3:0]        rsp_idx_ff;

   // fields of the entry being checked
   logic [ADDR_W-1:0] rd_up, rd_lo;
   logic [TIME_W-1:0] rd_start, age;
   logic [CNT_W-1:0]  rd_cnt, cnt_eff;
   logic              chk_full, match, restart, refuse;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_LENGTH_RST;
         max_ff <= MAX_PER_WINDOW_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: window_ff <= csr_wdata;
            CSR_MAX_PER_WINDOW: max_ff <= csr_wdata[CNT_W-1:0];
            default: window_ff <= window_ff;
         endcase
      end
   end

   // request capture, IPv4 keeps only the low 32 address bits
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         clr_ff <= req_type;
         req_fam_ff <= req_addr_family;
         now_ff <= req_now_ms;
         if (req_addr_family == FAM_IPV4) begin
            req_up_ff <= '0;
            req_lo_ff <= {32'd0, req_addr_lower[31:0]};
         end else begin
            req_up_ff <= req_addr_upper;
            req_lo_ff <= req_addr_lower;
         end
      end
   end

   // bucket family flops, cleared at once by reset or a clear request
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_tbl) begin
         for (int i = 0; i < BUCKETS; i++) begin
            family_ff[i] <= FAM_NONE;
         end
      end else if (cmd.write_entry) begin
         family_ff[upd_idx_ff] <= req_fam_ff;
      end
   end

   // bucket memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         bucket_mem[upd_idx_ff] <= {req_up_ff, req_lo_ff, upd_start_ff, upd_cnt_ff};
      end
      if (issuing) begin
         rd_data_ff <= bucket_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (issuing) begin
         rd_fam_ff <= family_ff[rd_idx_ff];
         chk_idx_ff <= rd_idx_ff;
      end
   end

   // read address sequencing
   assign issuing = cmd.scan_en && !issue_done_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.start_scan) begin
         rd_idx_ff <= '0;
         issue_done_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
      end else begin
         chk_vld_ff <= issuing;
         if (issuing) begin
            if (rd_idx_ff == LAST_IDX) issue_done_ff <= 1'b1;
            else rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   // request classification, compare and age of the entry under check
   always_comb begin
      sts.is_clear = clr_ff;
      sts.is_untracked = (req_fam_ff == FAM_NONE) || (req_fam_ff == FAM_RSVD) ||
                         ((req_up_ff == '0) && (req_lo_ff == '0));
      sts.out_free = !rsp_valid_ff || rsp_ready;
      {rd_up, rd_lo, rd_start, rd_cnt} = rd_data_ff;
      age = now_ff - rd_start;
      chk_full = rd_fam_ff != FAM_NONE;
      match = (rd_fam_ff == req_fam_ff) && (rd_up == req_up_ff) && (rd_lo == req_lo_ff);
      restart = age >= window_ff;
      cnt_eff = restart ? '0 : rd_cnt;
      refuse = cnt_eff >= max_ff;
      sts.scan_hit = cmd.scan_en && chk_vld_ff && match;
      sts.scan_done = cmd.scan_en && chk_vld_ff && !match && (chk_idx_ff == LAST_IDX);
   end

   // first empty, first expired and oldest bucket trackers
   always_comb begin
      empty_found_in = empty_found_ff;
      empty_idx_in = empty_idx_ff;
      exp_found_in = exp_found_ff;
      exp_idx_in = exp_idx_ff;
      oldest_idx_in = oldest_idx_ff;
      oldest_age_in = oldest_age_ff;
      if (chk_vld_ff && !chk_full && !empty_found_ff) begin
         empty_found_in = 1'b1;
         empty_idx_in = chk_idx_ff;
      end
      if (chk_vld_ff && chk_full && !match) begin
         if (!exp_found_ff && restart) begin
            exp_found_in = 1'b1;
            exp_idx_in = chk_idx_ff;
         end
         if ((chk_idx_ff == '0) || (age > oldest_age_ff)) begin
            oldest_idx_in = chk_idx_ff;
            oldest_age_in = age;
         end
      end
      if (empty_found_in) slot = empty_idx_in;
      else if (exp_found_in) slot = exp_idx_in;
      else slot = oldest_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start_scan) begin
         empty_found_ff <= 1'b0;
         empty_idx_ff <= '0;
         exp_found_ff <= 1'b0;
         exp_idx_ff <= '0;
         oldest_idx_ff <= '0;
         oldest_age_ff <= '0;
      end else if (cmd.scan_en) begin
         empty_found_ff <= empty_found_in;
         empty_idx_ff <= empty_idx_in;
         exp_found_ff <= exp_found_in;
         exp_idx_ff <= exp_idx_in;
         oldest_idx_ff <= oldest_idx_in;
         oldest_age_ff <= oldest_age_in;
      end
   end

   // bucket update values and pending result
   always_ff @(posedge clock) begin
      if (cmd.set_clear_res) begin
         res_allowed_ff <= 1'b0;
         res_outcome_ff <= OUT_CLEARED;
         res_idx_ff <= '0;
      end else if (cmd.set_untracked_res) begin
         res_allowed_ff <= 1'b1;
         res_outcome_ff <= OUT_UNTRACKED;
         res_idx_ff <= '0;
      end else if (sts.scan_hit) begin
         upd_idx_ff <= chk_idx_ff;
         upd_start_ff <= restart ? now_ff : rd_start;
         upd_cnt_ff <= refuse ? cnt_eff : cnt_eff + 1'b1;
         res_allowed_ff <= !refuse;
         res_outcome_ff <= refuse ? OUT_REFUSED : OUT_COUNTED;
         res_idx_ff <= chk_idx_ff;
      end else if (sts.scan_done) begin
         upd_idx_ff <= slot;
         upd_start_ff <= now_ff;
         upd_cnt_ff <= CNT_W'(1);
         res_allowed_ff <= 1'b1;
         res_outcome_ff <= OUT_NEW;
         res_idx_ff <= slot;
      end
   end

   // output word register
   assign res_idx_wide = {4'b0000, res_idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_allowed_ff <= res_allowed_ff;
         rsp_outcome_ff <= res_outcome_ff;
         rsp_idx_ff <= res_idx_wide[3:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_bucket_index = rsp_idx_ff;

   // a hit and a miss never end the same scan
   a_hit_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(sts.scan_hit && sts.scan_done))
      else $error("scan ended as hit and miss together");

   // a miss is only declared after every bucket was read
   a_done_all_read: assert property (@(posedge clock) disable iff (reset)
      sts.scan_done |-> issue_done_ff)
      else $error("scan finished before all buckets were read");

   // a written bucket carries the request family afterwards
   a_write_family: assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry && !cmd.clear_tbl |=> family_ff[$past(upd_idx_ff)] == $past(req_fam_ff))
      else $error("bucket family not updated on write");

endmodule

@@ rtl/core/per_source_accept_throttle.sv @@
// top level of the per-source accept throttle
//
//   channel   direction  ports
//   req       in         req_valid/req_ready, type, family, address words, now_ms
//   rsp       out        rsp_valid/rsp_ready, allowed, outcome, bucket_index
//   csr       in         csr_write_en, csr_index, csr_wdata (write only)
//
// a clear or an untracked source gives its word without a scan; a tracked
// source scans the bucket memory through its one registered read port, one
// bucket per cycle, and stops the scan early on a hit.
// one request is worked at a time; a new one is taken while the last word waits.
// synchronous active-high reset empties the table and loads the register defaults.
// rsp_ready low holds the word; the next result waits until the register is free.
module per_source_accept_throttle import psat_pkg::*; #(
   parameter int BUCKETS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [1:0]  req_addr_family,
   input  logic [63:0] req_addr_upper,
   input  logic [63:0] req_addr_lower,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_allowed,
   output logic [2:0]  rsp_outcome,
   output logic [3:0]  rsp_bucket_index,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // sequencing
   psat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, scan and result path
   psat_dp #(
      .BUCKETS (BUCKETS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_addr_family  (req_addr_family),
      .req_addr_upper   (req_addr_upper),
      .req_addr_lower   (req_addr_lower),
      .req_now_ms       (req_now_ms),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_allowed      (rsp_allowed),
      .rsp_outcome      (rsp_outcome),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule
